FILE: design/lpf_pkg.sv
// Shared types and constants of the 6LoWPAN datagram fragmenter.
package lpf_pkg;

    // Header kind that precedes the data byte of one queued job.
    typedef enum logic [1:0] {
        HDR_NONE  = 2'd0,
        HDR_FRAG1 = 2'd1,
        HDR_FRAGN = 2'd2
    } t_hdr;

    localparam logic [7:0] FRAG1_DISPATCH = 8'hC0;
    localparam logic [7:0] FRAGN_DISPATCH = 8'hE0;
    localparam int         FRAG1_HDR_LEN  = 4;
    localparam int         FRAGN_HDR_LEN  = 5;
    localparam logic [7:0] CAP_MASK       = 8'hF8;
    localparam logic [7:0] MIN_CAP        = 8'd8;
    localparam logic [7:0] LIMIT_RESET    = 8'd102;
    localparam int         QUEUE_DEPTH_DEFAULT = 2;

    // One classified input byte, with everything the back end needs to emit it.
    typedef struct packed {
        logic [7:0]  data;
        t_hdr        hdr;
        logic [10:0] size;
        logic [15:0] tag;
        logic [7:0]  offset;
        logic        frag_end;
        logic        dgram_end;
    } t_job;

endpackage

FILE: design/lpf_front.sv
// Front end: frame-limit register, datagram state and classification of input bytes.
module lpf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_last_byte,
    input  logic [10:0]        i_datagram_size,
    input  logic [5:0]         i_dispatch_bytes,
    output logic               o_push,
    output lpf_pkg::t_job      o_job
);

    logic [7:0]  r_frag_limit;
    logic [15:0] r_tag;
    logic [7:0]  r_bif;
    logic [7:0]  r_cap;
    logic [10:0] r_off;
    logic [10:0] r_size;
    logic [5:0]  r_disp;
    logic        r_iff;

    logic [15:0] n_tag;
    logic [7:0]  n_bif;
    logic [7:0]  n_cap;
    logic [10:0] n_off;
    logic [10:0] n_size;
    logic [5:0]  n_disp;
    logic        n_iff;

    logic [15:0] job_tag;
    logic [7:0]  bif_inc;
    logic        drop;
    lpf_pkg::t_hdr hdr;

    // Room for datagram bytes after the overhead, in whole 8-byte units, at least 8.
    function automatic logic [7:0] room8(input logic [7:0] limit, input logic [6:0] overhead);
        logic [7:0] diff;
        logic [7:0] r;
        diff = limit - {1'b0, overhead};
        r    = (limit > {1'b0, overhead}) ? (diff & lpf_pkg::CAP_MASK) : 8'd0;
        return (r < lpf_pkg::MIN_CAP) ? lpf_pkg::MIN_CAP : r;
    endfunction

    always_comb begin
        n_tag   = r_tag;
        n_bif   = r_bif;
        n_cap   = r_cap;
        n_off   = r_off;
        n_size  = r_size;
        n_disp  = r_disp;
        n_iff   = r_iff;
        job_tag = r_tag;
        drop    = 1'b0;
        hdr     = lpf_pkg::HDR_NONE;

        if (i_first_byte) begin
            // A new datagram; an open one is abandoned and uses up its tag.
            job_tag = r_tag + {15'd0, (r_cap != 8'd0)};
            n_tag   = job_tag;
            n_size  = i_datagram_size;
            n_disp  = i_dispatch_bytes;
            n_cap   = room8(r_frag_limit, {1'b0, i_dispatch_bytes} + 7'(lpf_pkg::FRAG1_HDR_LEN))
                      + {2'b00, i_dispatch_bytes};
            n_bif   = 8'd0;
            n_off   = 11'd0;
            n_iff   = 1'b1;
            hdr     = lpf_pkg::HDR_FRAG1;
        end else if (r_cap == 8'd0) begin
            drop = 1'b1;
        end else if (r_bif >= r_cap) begin
            n_iff = 1'b0;
            n_cap = room8(r_frag_limit, 7'(lpf_pkg::FRAGN_HDR_LEN));
            n_bif = 8'd0;
            hdr   = lpf_pkg::HDR_FRAGN;
        end

        // Dispatch bytes of the first fragment do not advance the datagram offset.
        if (!(n_iff && (n_bif < {2'b00, n_disp}))) begin
            n_off = n_off + 11'd1;
        end
        bif_inc = n_bif + 8'd1;
        n_bif   = bif_inc;

        o_job.data      = i_data_byte;
        o_job.hdr       = hdr;
        o_job.size      = n_size;
        o_job.tag       = job_tag;
        o_job.offset    = r_off[10:3];
        o_job.frag_end  = i_last_byte || (bif_inc >= n_cap);
        o_job.dgram_end = i_last_byte;

        if (i_last_byte) begin
            n_tag = job_tag + 16'd1;
            n_cap = 8'd0;
            n_bif = 8'd0;
            n_off = 11'd0;
            n_iff = 1'b1;
        end
    end

    assign o_push = i_accept && !drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_limit <= lpf_pkg::LIMIT_RESET;
            r_tag        <= 16'd0;
            r_bif        <= 8'd0;
            r_cap        <= 8'd0;
            r_off        <= 11'd0;
            r_size       <= 11'd0;
            r_disp       <= 6'd0;
            r_iff        <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_frag_limit <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_tag  <= n_tag;
                r_bif  <= n_bif;
                r_cap  <= n_cap;
                r_off  <= n_off;
                r_size <= n_size;
                r_disp <= n_disp;
                r_iff  <= n_iff;
            end
        end
    end

endmodule

FILE: design/lpf_queue.sv
// Short job queue between the front end and the back end.
module lpf_queue #(
    parameter int DEPTH = lpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_head_valid,
    output lpf_pkg::t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    lpf_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("queue popped while empty");

endmodule

FILE: design/lpf_back.sv
// Back end: header byte sequencer and output register.
module lpf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  lpf_pkg::t_job i_head,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_fragment_start,
    output logic          o_fragment_end,
    output logic          o_datagram_end
);

    localparam logic [2:0] STEP_DISP   = 3'd0;
    localparam logic [2:0] STEP_SIZE   = 3'd1;
    localparam logic [2:0] STEP_TAG_HI = 3'd2;
    localparam logic [2:0] STEP_TAG_LO = 3'd3;
    localparam logic [2:0] STEP_OFFSET = 3'd4;

    logic [2:0] r_step;
    logic [2:0] n_step;
    logic [2:0] data_step;
    logic       is_data;
    logic       advance;
    logic [7:0] beat_byte;
    logic       beat_start;
    logic       beat_fend;
    logic       beat_dend;
    logic [7:0] disp;

    always_comb begin
        case (i_head.hdr)
            lpf_pkg::HDR_FRAG1: data_step = 3'(lpf_pkg::FRAG1_HDR_LEN);
            lpf_pkg::HDR_FRAGN: data_step = 3'(lpf_pkg::FRAGN_HDR_LEN);
            default:            data_step = STEP_DISP;
        endcase
    end

    assign is_data = (r_step == data_step);
    assign advance = i_head_valid && (!o_out_valid || i_out_ready);
    assign o_pop   = advance && is_data;
    assign n_step  = is_data ? STEP_DISP : r_step + 3'd1;
    assign disp    = (i_head.hdr == lpf_pkg::HDR_FRAG1) ? lpf_pkg::FRAG1_DISPATCH
                                                        : lpf_pkg::FRAGN_DISPATCH;

    always_comb begin
        beat_start = 1'b0;
        beat_fend  = 1'b0;
        beat_dend  = 1'b0;
        if (is_data) begin
            beat_byte = i_head.data;
            beat_fend = i_head.frag_end;
            beat_dend = i_head.dgram_end;
        end else begin
            case (r_step)
                STEP_DISP: begin
                    beat_byte  = disp | {5'd0, i_head.size[10:8]};
                    beat_start = 1'b1;
                end
                STEP_SIZE:   beat_byte = i_head.size[7:0];
                STEP_TAG_HI: beat_byte = i_head.tag[15:8];
                STEP_TAG_LO: beat_byte = i_head.tag[7:0];
                STEP_OFFSET: beat_byte = i_head.offset;
                default:     beat_byte = i_head.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_DISP;
            o_out_valid <= 1'b0;
        end else if (advance) begin
            r_step      <= n_step;
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_out_byte       <= beat_byte;
            o_fragment_start <= beat_start;
            o_fragment_end   <= beat_fend;
            o_datagram_end   <= beat_dend;
        end
    end

    a_start_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fragment_start) |-> !o_fragment_end)
        else $error("header byte flagged as fragment end");

    a_dgram_end_closes_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_datagram_end) |-> o_fragment_end)
        else $error("datagram end without fragment end");

    a_header_holds_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_DISP) |-> i_head_valid)
        else $error("job left the queue in the middle of its header");

endmodule

FILE: design/lowpan_datagram_fragmenter.sv
// Top level of the 6LoWPAN datagram fragmenter.
//
//  Channel   Direction  Handshake                  Payload
//  ------------------------------------------------------------------------------------
//  in        input      i_in_valid / o_in_ready    i_data_byte, i_first_byte,
//                                                  i_last_byte, i_datagram_size,
//                                                  i_dispatch_bytes
//  out       output     o_out_valid / i_out_ready  o_out_byte, o_fragment_start,
//                                                  o_fragment_end, o_datagram_end
//  cfg       input      i_cfg_wr_en (no wait)      i_cfg_wr_data (frag_limit)
//
// An accepted payload beat is written into the job queue through the combinational
// front end and then into the back end's output register.
// Payload beats stream at one per cycle while the output is ready; a beat that opens
// a fragment is preceded by four (first fragment) or five (later fragments) header
// bytes from the back end's one-byte-per-cycle header sequencer.
// Synchronous active-low reset sets the tag to zero, closes any datagram and sets
// frag_limit to 102; the queue and output register come up empty.
// Output stalls back up through the queue; the input keeps accepting until the
// QUEUE_DEPTH-entry queue is full.
module lowpan_datagram_fragmenter #(
    parameter int QUEUE_DEPTH = lpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [10:0] i_datagram_size,
    input  logic [5:0]  i_dispatch_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_fragment_start,
    output logic        o_fragment_end,
    output logic        o_datagram_end
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          full;
    logic          head_valid;
    lpf_pkg::t_job job;
    lpf_pkg::t_job head;

    // Bytes outside an open datagram are accepted and dropped by the front end.
    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    lpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_first_byte     (i_first_byte),
        .i_last_byte      (i_last_byte),
        .i_datagram_size  (i_datagram_size),
        .i_dispatch_bytes (i_dispatch_bytes),
        .o_push           (push),
        .o_job            (job)
    );

    lpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // The back end keeps a job at the queue head until its data byte goes out.
    lpf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_fragment_start (o_fragment_start),
        .o_fragment_end   (o_fragment_end),
        .o_datagram_end   (o_datagram_end)
    );

endmodule

FILE: verif/lowpan_datagram_fragmenter_test.sv
// Self-checking testbench for the 6LoWPAN datagram fragmenter.
module lowpan_datagram_fragmenter_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped as failed if it ever gets this far. The slowest correct
    // run (every beat making six output beats, each waiting out the longest
    // receiver gap) stays well below a third of it.
    localparam int CYCLE_LIMIT = 200_000;
    // The fragmenter moves a beat from input to output through its job queue and
    // output register; the extra wait covers a dropped byte that makes no output.
    localparam int DRAIN_CYCLES = 10;
    localparam int GAP_MAX = 18;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER = 200;
    localparam int PHASE_BEATS = 32;
    localparam logic [7:0] LIMIT_MIN = 8'd16;
    localparam logic [7:0] LIMIT_MAX = 8'd255;

    // The predictor of the fragmenter and the store of the output beats it
    // still owes. Input beats are fed in as they are accepted and output beats
    // are compared against the oldest owed beat.
    class frag_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       frag_start;
            logic       frag_end;
            logic       dgram_end;
        } t_out_beat;

        logic [7:0]  frag_limit;
        logic [15:0] tag;
        logic [7:0]  fill;
        logic [7:0]  capacity;
        logic [10:0] offset;
        logic [10:0] held_size;
        logic [5:0]  held_dispatch;
        logic        in_frag1;
        t_out_beat   owed_beats[$];
        int          mismatches;
        int          beats_checked;
        int          fragments_seen;
        int          datagrams_seen;

        function new();
            frag_limit = lpf_pkg::LIMIT_RESET;
            tag = '0;
            fill = '0;
            capacity = '0;
            offset = '0;
            held_size = '0;
            held_dispatch = '0;
            in_frag1 = 1'b1;
            mismatches = 0;
            beats_checked = 0;
            fragments_seen = 0;
            datagrams_seen = 0;
        endfunction

        // Datagram bytes that fit behind a header, in whole 8-byte units and
        // never fewer than eight.
        function logic [7:0] payload_room(int unsigned overhead);
            int unsigned room;
            room = (frag_limit > overhead) ?
                   ((frag_limit - overhead) & lpf_pkg::CAP_MASK) : 0;
            return (room < lpf_pkg::MIN_CAP) ? lpf_pkg::MIN_CAP : room[7:0];
        endfunction

        function void owe_beat(logic [7:0] data, logic fs, logic fe, logic de);
            t_out_beat b;
            b.data = data;
            b.frag_start = fs;
            b.frag_end = fe;
            b.dgram_end = de;
            owed_beats.push_back(b);
        endfunction

        // The four bytes that FRAG1 and FRAGN headers share.
        function void owe_header(logic [7:0] dispatch);
            owe_beat(dispatch | {5'b0, held_size[10:8]}, 1'b1, 1'b0, 1'b0);
            owe_beat(held_size[7:0], 1'b0, 1'b0, 1'b0);
            owe_beat(tag[15:8], 1'b0, 1'b0, 1'b0);
            owe_beat(tag[7:0], 1'b0, 1'b0, 1'b0);
        endfunction

        // Returns 1 when the byte belongs to a datagram and 0 when it is dropped.
        function int take_input(logic [7:0] data, logic first, logic last,
                                logic [10:0] size, logic [5:0] dispatch);
            if (first) begin
                // A new start while a datagram is open abandons that datagram.
                if (capacity != 0) tag = tag + 1'b1;
                held_size = size;
                held_dispatch = dispatch;
                capacity = payload_room(held_dispatch + lpf_pkg::FRAG1_HDR_LEN)
                           + held_dispatch;
                fill = '0;
                offset = '0;
                in_frag1 = 1'b1;
                owe_header(lpf_pkg::FRAG1_DISPATCH);
            end else begin
                if (capacity == 0) return 0;
                if (fill >= capacity) begin
                    in_frag1 = 1'b0;
                    capacity = payload_room(lpf_pkg::FRAGN_HDR_LEN);
                    fill = '0;
                    owe_header(lpf_pkg::FRAGN_DISPATCH);
                    owe_beat(offset[10:3], 1'b0, 1'b0, 1'b0);
                end
            end
            // Dispatch bytes ride in the first fragment but are not datagram bytes.
            if (!(in_frag1 && fill < held_dispatch)) offset = offset + 1'b1;
            fill = fill + 1'b1;
            owe_beat(data, 1'b0, last || fill >= capacity, last);
            if (last) begin
                tag = tag + 1'b1;
                capacity = '0;
                fill = '0;
                offset = '0;
                in_frag1 = 1'b1;
            end
            return 1;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(logic [7:0] data, logic fs, logic fe, logic de);
            t_out_beat want;
            beats_checked++;
            if (fs) fragments_seen++;
            if (de) datagrams_seen++;
            if (owed_beats.size() == 0) begin
                $error("out_byte: expected no beat, actual %0h", data);
                mismatches++;
                return;
            end
            want = owed_beats.pop_front();
            compare_field("out_byte", want.data, data);
            compare_field("fragment_start", want.frag_start, fs);
            compare_field("fragment_end", want.frag_end, fe);
            compare_field("datagram_end", want.dgram_end, de);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_first_byte;
    logic        i_last_byte;
    logic [10:0] i_datagram_size;
    logic [5:0]  i_dispatch_bytes;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_fragment_start;
    logic        o_fragment_end;
    logic        o_datagram_end;

    frag_scoreboard sb = new();
    int cycle_count = 0;
    int payload_beats_taken = 0;
    int limit_settings = 0;
    // Remaining beats of a no-gap stretch, one counter per side.
    int send_burst = 0;
    int recv_burst = 0;

    lowpan_datagram_fragmenter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_first_byte     (i_first_byte),
        .i_last_byte      (i_last_byte),
        .i_datagram_size  (i_datagram_size),
        .i_dispatch_bytes (i_dispatch_bytes),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_fragment_start (o_fragment_start),
        .o_fragment_end   (o_fragment_end),
        .o_datagram_end   (o_datagram_end)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle cycles before the next beat. Now and then a side runs a stretch of
    // beats back to back so that full-rate streaming is exercised as well.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Offers one beat on the input channel and returns right after the edge at
    // which it was taken. Inputs only change on falling edges. Valid is lowered
    // only when a gap follows, so back-to-back beats keep it high throughout.
    task automatic send_beat(input logic [7:0] data, input logic first, input logic last,
                             input logic [10:0] size, input logic [5:0] dispatch);
        int gap;
        gap = draw_gap(send_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_byte = data;
        i_first_byte = first;
        i_last_byte = last;
        i_datagram_size = size;
        i_dispatch_bytes = dispatch;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        payload_beats_taken += sb.take_input(data, first, last, size, dispatch);
    endtask

    // Lowers valid before the next rising edge so the last beat is not taken twice.
    task automatic pause_sender();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Waits until every owed beat has come out, then lets the pipeline settle
    // in case the last input was a dropped byte still on its way through.
    task automatic wait_for_drain();
        while (sb.owed_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The limit is only changed with the fragmenter idle. A datagram may still
    // be open across the change; its later fragments use the new limit.
    task automatic write_frag_limit(input logic [7:0] value);
        pause_sender();
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.frag_limit = value;
        limit_settings++;
    endtask

    // One datagram with random content. An abandoned one never sees its last
    // byte; whatever comes next restarts or extends it.
    task automatic send_datagram(input int len, input logic [5:0] dispatch,
                                 input logic [10:0] size, input bit abandon);
        for (int i = 0; i < len; i++) begin
            send_beat(8'($urandom_range(0, 255)), i == 0, (i == len - 1) && !abandon,
                      (i == 0) ? size : 11'($urandom_range(0, 2047)),
                      (i == 0) ? dispatch : 6'($urandom_range(0, 63)));
        end
    endtask

    // Mostly well-formed datagrams, with some stray bytes and some datagrams
    // cut short by a restart. Lengths are usually short so that headers come
    // often, with the occasional datagram spanning many fragments.
    task automatic send_mixed_traffic(input int target);
        int start;
        int kind;
        int len;
        logic [5:0] dispatch;
        start = payload_beats_taken;
        while (payload_beats_taken < start + target) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                          11'($urandom_range(0, 2047)), 6'($urandom_range(0, 63)));
            end else begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 24);
                dispatch = $urandom_range(0, 1) ? 6'($urandom_range(0, 3))
                                                : 6'($urandom_range(0, 63));
                send_datagram(len, dispatch, 11'($urandom_range(0, 2047)), kind == 1);
            end
        end
    endtask

    // Output side. Ready idles at random between beats; once, after enough
    // beats have been checked and while the sender is offering, it stays low
    // for a long stretch so the queue fills and the input stalls.
    initial begin : receiver
        int gap;
        bit held_off;
        held_off = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(recv_burst);
            if (!held_off && sb.beats_checked >= HOLD_OFF_AFTER && i_in_valid) begin
                held_off = 1'b1;
                gap = HOLD_OFF_CYCLES;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_beat(o_out_byte, o_fragment_start, o_fragment_end, o_datagram_end);
        end
    end

    initial begin : stimulus
        logic [7:0] phase_limits[5];
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_first_byte = 1'b0;
        i_last_byte = 1'b0;
        i_datagram_size = '0;
        i_dispatch_bytes = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats at the smallest limit, where every fragment holds
        // eight datagram bytes and headers come quickly.
        write_frag_limit(LIMIT_MIN);
        // A byte with no datagram open is dropped.
        send_beat(8'h00, 1'b0, 1'b0, 11'd0, 6'd0);
        // A one-byte datagram, with so many dispatch bytes that the room left
        // behind the header falls back to the eight-byte minimum.
        send_beat(8'hFF, 1'b1, 1'b1, 11'h7FF, 6'h3F);
        // One dispatch byte plus ten datagram bytes: nine fill the first
        // fragment and the rest go out behind a FRAGN header.
        for (int i = 0; i < 11; i++) begin
            send_beat(i[0] ? 8'hFF : 8'h00, i == 0, i == 10, 11'd0, 6'd1);
        end
        // A datagram dropped by a new start, followed by one that ends exactly
        // on a fragment boundary.
        send_beat(8'h5A, 1'b1, 1'b0, 11'h2AA, 6'd1);
        send_beat(8'hA5, 1'b0, 1'b0, 11'h2AA, 6'd1);
        for (int i = 0; i < 8; i++) begin
            send_beat(8'h3C + 8'(i), i == 0, i == 7, 11'h555, 6'd0);
        end
        // A last-byte flag on a byte outside any datagram is dropped as well.
        send_beat(8'hC3, 1'b0, 1'b1, 11'h7FF, 6'h3F);

        phase_limits[0] = LIMIT_MAX;
        phase_limits[1] = LIMIT_MIN;
        phase_limits[2] = 8'($urandom_range(17, 254));
        phase_limits[3] = lpf_pkg::LIMIT_RESET;
        phase_limits[4] = 8'($urandom_range(LIMIT_MIN, LIMIT_MAX));
        foreach (phase_limits[p]) begin
            write_frag_limit(phase_limits[p]);
            send_mixed_traffic(PHASE_BEATS);
        end

        pause_sender();
        wait_for_drain();
        $display("Fed %0d datagram beats under %0d link limit settings.",
                 payload_beats_taken, limit_settings);
        $display("Compared %0d output beats in %0d fragments closing %0d datagrams.",
                 sb.beats_checked, sb.fragments_seen, sb.datagrams_seen);
        if (sb.mismatches == 0 && sb.owed_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
